// ===== sv/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Operation and status codes and the result word shared by the deque modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_SEARCH     = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_POP_BACK   = 3'd4;
   localparam logic [2:0] OP_REVERSE    = 3'd5;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [6:0] count;
   } bdq_result_type;

endpackage

`default_nettype wire

// ===== sv/bdq_store.sv =====
// ----------------------------------------------------------------------------
// Deque entry store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [31:0]   rd_data
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/bdq_seq.sv =====
// ----------------------------------------------------------------------------
// Deque sequencer
// Holds the ring pointers and direction flag, performs pushes, pops and
// reversal at once, and walks the store one entry per cycle for a search.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_seq
   import bdq_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic [2:0]     req_opcode,
   input  wire logic [31:0]    req_value,
   input  wire logic           out_free,
   output logic                req_stall,
   output logic                done,
   output bdq_result_type      result,
   output logic                wr_en,
   output logic      [AW-1:0]  wr_addr,
   output logic      [31:0]    wr_data,
   output logic                rd_en,
   output logic      [AW-1:0]  rd_addr,
   input  wire logic [31:0]    rd_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic          state_ff, state_in;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;
   logic [31:0]   key_ff, key_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          rd_last_ff, rd_last_in;

   logic          accept;
   logic          full;
   logic          empty;
   logic          issuing;
   logic [AW-1:0] front_dec;
   logic [AW-1:0] front_inc;
   logic [AW-1:0] addr_inc;
   logic [AW:0]   back_sum;
   logic [AW-1:0] back_pos;
   logic [CW+6:0] count_ext;

   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign issuing   = (issue_ff != count_ff);

   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
   assign addr_inc  = (addr_ff == AW'(DEPTH - 1)) ? '0 : addr_ff + AW'(1);
   assign back_sum  = {1'b0, front_ff} + (AW+1)'(count_ff);
   assign back_pos  = (back_sum >= (AW+1)'(DEPTH)) ?
                      AW'(back_sum - (AW+1)'(DEPTH)) : AW'(back_sum);
   assign count_ext = {7'b0, count_in};

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      rev_in        = rev_ff;
      key_in        = key_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      rd_last_in    = 1'b0;
      done          = 1'b0;
      result.status = ST_DONE;
      result.found  = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = back_pos;
      wr_data       = req_value;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               done = 1'b1;
               unique case (req_opcode)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (full) begin
                        result.status = ST_FULL;
                     end else if ((req_opcode == OP_PUSH_FRONT) != rev_ff) begin
                        front_in = front_dec;
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        count_in = count_ff + CW'(1);
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_SEARCH: begin
                     key_in = req_value;
                     if (!empty) begin
                        done     = 1'b0;
                        state_in = ST_SCAN;
                        addr_in  = front_ff;
                        issue_in = '0;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (empty) begin
                        result.status = ST_EMPTY;
                     end else if ((req_opcode == OP_POP_FRONT) != rev_ff) begin
                        front_in = front_inc;
                        count_in = count_ff - CW'(1);
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_REVERSE: begin
                     rev_in = !rev_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_en = issuing;
            if (issuing) begin
               addr_in  = addr_inc;
               issue_in = issue_ff + CW'(1);
            end
            // Read data comes from the store's output register; compare the word
            // returned for the previous address.
            if (rd_valid_ff && (rd_data == key_ff)) begin
               done         = 1'b1;
               result.found = 1'b1;
               state_in     = ST_IDLE;
            end else if (rd_valid_ff && rd_last_ff) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_valid_in = issuing;
               rd_last_in  = issuing && (issue_ff == count_ff - CW'(1));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      result.count = count_ext[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         front_ff    <= '0;
         count_ff    <= '0;
         rev_ff      <= 1'b0;
         issue_ff    <= '0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         front_ff    <= front_in;
         count_ff    <= count_in;
         rev_ff      <= rev_in;
         issue_ff    <= issue_in;
         rd_valid_ff <= rd_valid_in;
         rd_last_ff  <= rd_last_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      addr_ff <= addr_in;
   end

endmodule

`default_nettype wire

// ===== sv/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// Bounded deque with linear search
// Ring-buffered double-ended queue of 32-bit values with push, pop, reverse
// and a search that compares the held entries one per cycle.
//
//   Channel   Ports                              Direction
//   req       req_valid req_stall req_opcode     in  (word: opcode, value)
//             req_value
//   rsp       rsp_valid rsp_stall rsp_status     out (word: status, found,
//             rsp_found rsp_count                     count)
//
// For push, pop, reverse and search of an empty list the result word is
// valid the cycle after the request is taken.
// A search uses the store's single read port, which reads one entry per
// cycle, and the scan stops at the first match.
// Reset clears the pointers, count and direction flag; the store is not
// cleared since only held entries are ever read.
// req_stall is high during a search and while a result word waits on rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search
   import bdq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [2:0]  req_opcode,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic             [1:0]  rsp_status,
   output logic                    rsp_found,
   output logic             [6:0]  rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic           rsp_valid_ff, rsp_valid_in;
   bdq_result_type rsp_ff;
   bdq_result_type result;
   logic           done;
   logic           out_free;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [31:0]    wr_data;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [31:0]    rd_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   bdq_seq #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .out_free   (out_free),
      .req_stall  (req_stall),
      .done       (done),
      .result     (result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   bdq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_found  = rsp_ff.found;
   assign rsp_count  = rsp_ff.count;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> out_free)
      else $error("result word produced while the held word is stalled");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (rsp_valid || req_stall))
      else $error("accepted request neither answered nor in progress");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_DONE))
      else $error("found flag set with a non-done status");

endmodule

`default_nettype wire
